/* hdl/assert_macros.svh */
// Assertion macros for the checker module psr_chk.
// Needs clk and rst in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, quiet while reset is high
`define PSR_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);

// clocked check that also runs through reset
`define PSR_ASSERT_RST(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hdl/psr_pkg.sv */
// Types, widths and shared arithmetic for the particle/wall reflect pipeline.
// No dependencies.
package psr_pkg;

  localparam int FRAC_BITS = 16;
  localparam int CW   = 32;
  localparam int DW   = CW + 1;
  localparam int PW   = 2 * DW;
  localparam int NW   = PW + 1;
  localparam int DENW = PW;
  localparam int KW   = PW;
  localparam int KMW  = PW - 1;
  localparam int KLW  = DW;
  localparam int KHW  = KMW - KLW;
  localparam int QW   = CW + 1;
  localparam int RNW  = DENW + QW;
  localparam int TW   = FRAC_BITS + 1;
  localparam int TDW  = TW + 1 + DW;
  localparam int DDW  = TDW - FRAC_BITS + 1;
  localparam int MW   = CW - 1;
  localparam int SQW  = 2 * MW + 1;
  localparam int HDW  = 31;
  localparam int THW  = HDW + FRAC_BITS;
  localparam int EW   = CW + 3;
  localparam int CIW  = 3;
  localparam int SW   = 3;

  localparam int SETTLE  = 4;
  localparam int FRONT_T = 4;
  localparam int FRONT_Q = 6;
  localparam int T_LAT   = FRAC_BITS + 5;
  localparam int Q_LAT   = QW + 1;
  localparam int HIT_DLY = FRONT_Q + Q_LAT - FRONT_T - T_LAT;
  localparam int OUT_LAT = FRONT_Q + Q_LAT + 1;

  localparam logic signed [CW-1:0] ONE_FX  = CW'(64'd1 << FRAC_BITS);
  localparam logic [HDW-1:0]       HIT_RST = HDW'((64'd51 << FRAC_BITS) / 100);

  typedef enum logic [CIW-1:0] {
    REG_START_X     = 3'd0,
    REG_START_Y     = 3'd1,
    REG_END_X       = 3'd2,
    REG_END_Y       = 3'd3,
    REG_HIT_DIST_SQ = 3'd4
  } cfg_reg_t;

  typedef enum logic [1:0] {
    TSEL_ZERO,
    TSEL_ONE,
    TSEL_DIV
  } tsel_t;

  typedef struct packed {
    logic signed [CW-1:0] pos_x;
    logic signed [CW-1:0] pos_y;
    logic signed [CW-1:0] vel_x;
    logic signed [CW-1:0] vel_y;
  } in_word_t;

  typedef struct packed {
    logic signed [CW-1:0] new_vel_x;
    logic signed [CW-1:0] new_vel_y;
    logic                 hit;
  } out_word_t;

  typedef struct packed {
    logic signed [CW-1:0] sx;
    logic signed [CW-1:0] sy;
    logic signed [DW-1:0] dx;
    logic signed [DW-1:0] dy;
    logic [DW-1:0]        adx;
    logic [DW-1:0]        ady;
    logic [DENW-1:0]      den;
    logic [THW-1:0]       thr;
    logic                 nz;
  } wall_t;

  typedef struct packed {
    logic signed [DW-1:0] rx;
    logic signed [DW-1:0] ry;
    logic [DENW-1:0]      rem;
    tsel_t                tsel;
  } tdin_t;

  typedef struct packed {
    logic [RNW-1:0]       nx;
    logic [RNW-1:0]       ny;
    logic signed [CW-1:0] vel_x;
    logic signed [CW-1:0] vel_y;
    logic                 flip_x;
    logic                 flip_y;
  } qdin_t;

  typedef struct packed {
    logic signed [CW-1:0] nvx;
    logic signed [CW-1:0] nvy;
    logic signed [CW-1:0] vel_x;
    logic signed [CW-1:0] vel_y;
  } qdout_t;

  // one restoring step: {quotient bit, new remainder}
  function automatic logic [DENW:0] div_step(input logic [DENW-1:0] rem,
                                             input logic nbit,
                                             input logic [DENW-1:0] den);
    logic [DENW:0] r2;
    logic [DENW:0] diff;
    logic          ge;
    r2   = {rem, nbit};
    ge   = (r2 >= {1'b0, den});
    diff = r2 - {1'b0, den};
    div_step = ge ? {1'b1, diff[DENW-1:0]} : {1'b0, r2[DENW-1:0]};
  endfunction

endpackage

/* hdl/particle_segment_reflect_top.sv */
// Top level: register file, wall-derived terms, pipeline assembly and result word.
// Depends on psr_pkg, psr_front, psr_tdiv, psr_qdiv.
//
// Takes one particle word per clock whenever busy is low and returns its result
// word strobed by done for one cycle; words come out in order and the receiver
// cannot hold them off. Each word passes the 6-stage front end and then the
// 33-stage restoring divider pair that forms the mirror correction; the 16-stage
// divider for the projection parameter and the distance test run alongside.
// Busy is high after reset and after every register write while the wall
// length and its square settle.
module particle_segment_reflect_top (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  psr_pkg::in_word_t     item,
  output logic                  done,
  output psr_pkg::out_word_t    result,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [psr_pkg::CIW-1:0] cfg_index,
  input  logic [psr_pkg::CW-1:0]  cfg_data
);
  import psr_pkg::*;

  logic signed [CW-1:0] start_x, start_y, end_x, end_y;
  logic [HDW-1:0]       hit_dist_sq;
  logic [SW-1:0]        settle;

  logic signed [DW-1:0] w_dx, w_dy;
  logic [DW-1:0]        w_adx, w_ady;
  logic [PW-1:0]        w_sqx, w_sqy;
  logic [DENW-1:0]      w_den;
  wall_t                wall;

  logic   take;
  logic   t_valid, q_valid, hit_valid, hit, o_valid;
  tdin_t  t_word;
  qdin_t  q_word;
  qdout_t o_word;
  logic   hit_line  [HIT_DLY];
  logic   hitv_line [HIT_DLY];
  logic   hit_now;

  assign cfg_ready = 1'b1;
  assign busy      = (settle != '0);
  assign take      = start & ~busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_x     <= '0;
      start_y     <= '0;
      end_x       <= ONE_FX;
      end_y       <= '0;
      hit_dist_sq <= HIT_RST;
      settle      <= SW'(SETTLE);
    end else begin
      if (cfg_valid && cfg_ready) begin
        settle <= SW'(SETTLE);
        unique case (cfg_reg_t'(cfg_index))
          REG_START_X:     start_x     <= cfg_data;
          REG_START_Y:     start_y     <= cfg_data;
          REG_END_X:       end_x       <= cfg_data;
          REG_END_Y:       end_y       <= cfg_data;
          REG_HIT_DIST_SQ: hit_dist_sq <= cfg_data[HDW-1:0];
          default: ;
        endcase
      end else if (settle != '0) begin
        settle <= settle - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    w_dx  <= $signed({end_x[CW-1], end_x}) - $signed({start_x[CW-1], start_x});
    w_dy  <= $signed({end_y[CW-1], end_y}) - $signed({start_y[CW-1], start_y});
    w_adx <= w_dx[DW-1] ? DW'(-w_dx) : DW'(w_dx);
    w_ady <= w_dy[DW-1] ? DW'(-w_dy) : DW'(w_dy);
    w_sqx <= w_adx * w_adx;
    w_sqy <= w_ady * w_ady;
    w_den <= w_sqx + w_sqy;
  end

  always_comb begin
    wall.sx  = start_x;
    wall.sy  = start_y;
    wall.dx  = w_dx;
    wall.dy  = w_dy;
    wall.adx = w_adx;
    wall.ady = w_ady;
    wall.den = w_den;
    wall.thr = {hit_dist_sq, {FRAC_BITS{1'b0}}};
    wall.nz  = |w_den;
  end

  psr_front u_front (
    .clk     (clk),
    .rst     (rst),
    .take    (take),
    .item    (item),
    .wall    (wall),
    .t_valid (t_valid),
    .t_word  (t_word),
    .q_valid (q_valid),
    .q_word  (q_word)
  );

  psr_tdiv u_tdiv (
    .clk       (clk),
    .rst       (rst),
    .t_valid   (t_valid),
    .t_word    (t_word),
    .wall      (wall),
    .hit_valid (hit_valid),
    .hit       (hit)
  );

  psr_qdiv u_qdiv (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_word    (q_word),
    .wall      (wall),
    .out_valid (o_valid),
    .out_word  (o_word)
  );

  // line the hit flag up with the correction pipeline
  always_ff @(posedge clk) begin
    hit_line[0]  <= hit;
    hitv_line[0] <= hit_valid;
    for (int i = 1; i < HIT_DLY; i++) begin
      hit_line[i]  <= hit_line[i-1];
      hitv_line[i] <= hitv_line[i-1];
    end
  end

  assign hit_now = hit_line[HIT_DLY-1] & hitv_line[HIT_DLY-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= o_valid;
    end
  end

  always_ff @(posedge clk) begin
    result.new_vel_x <= hit_now ? o_word.nvx : o_word.vel_x;
    result.new_vel_y <= hit_now ? o_word.nvy : o_word.vel_y;
    result.hit       <= hit_now;
  end

endmodule

/* hdl/psr_front.sv */
// Front end: offsets, dot and cross products, projection classify, reflect numerators.
// Depends on psr_pkg.
module psr_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            take,
  input  psr_pkg::in_word_t item,
  input  psr_pkg::wall_t  wall,
  output logic            t_valid,
  output psr_pkg::tdin_t  t_word,
  output logic            q_valid,
  output psr_pkg::qdin_t  q_word
);
  import psr_pkg::*;

  logic [FRONT_Q-1:0] vld;

  logic signed [DW-1:0] rx1, ry1, rx2, ry2, rx3, ry3;
  logic signed [CW-1:0] vx1, vy1, vx2, vy2, vx3, vy3, vx4, vy4, vx5, vy5;
  logic signed [PW-1:0] prx2, pry2, pkx2, pky2;
  logic signed [NW-1:0] num3;
  logic signed [KW-1:0] k3;
  logic [KW-1:0]        kabs;
  tsel_t                tsel;
  tdin_t                t4;
  logic [KMW-1:0]       kmag4;
  logic                 fx4, fy4, fx5, fy5;
  logic [KHW+DW-1:0]    pxh5, pyh5;
  logic [PW-1:0]        pxl5, pyl5;
  qdin_t                q6;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[FRONT_Q-2:0], take};
    end
  end

  always_comb begin
    kabs = k3[KW-1] ? (~k3 + 1'b1) : k3;
    if (num3[NW-1]) begin
      tsel = TSEL_ZERO;
    end else if (num3[DENW-1:0] >= wall.den) begin
      tsel = TSEL_ONE;
    end else begin
      tsel = TSEL_DIV;
    end
  end

  always_ff @(posedge clk) begin
    rx1 <= $signed({item.pos_x[CW-1], item.pos_x}) - $signed({wall.sx[CW-1], wall.sx});
    ry1 <= $signed({item.pos_y[CW-1], item.pos_y}) - $signed({wall.sy[CW-1], wall.sy});
    vx1 <= item.vel_x;
    vy1 <= item.vel_y;

    prx2 <= rx1 * wall.dx;
    pry2 <= ry1 * wall.dy;
    pkx2 <= vy1 * wall.dx;
    pky2 <= vx1 * wall.dy;
    rx2  <= rx1;
    ry2  <= ry1;
    vx2  <= vx1;
    vy2  <= vy1;

    num3 <= prx2 + pry2;
    k3   <= pkx2 - pky2;
    rx3  <= rx2;
    ry3  <= ry2;
    vx3  <= vx2;
    vy3  <= vy2;

    t4.rx   <= rx3;
    t4.ry   <= ry3;
    t4.rem  <= num3[DENW-1:0];
    t4.tsel <= tsel;
    kmag4   <= kabs[KMW-1:0];
    fx4     <= k3[KW-1] ^ wall.dy[DW-1];
    fy4     <= k3[KW-1] ^ wall.dx[DW-1];
    vx4     <= vx3;
    vy4     <= vy3;

    pxh5 <= kmag4[KMW-1:KLW] * wall.ady;
    pxl5 <= kmag4[KLW-1:0] * wall.ady;
    pyh5 <= kmag4[KMW-1:KLW] * wall.adx;
    pyl5 <= kmag4[KLW-1:0] * wall.adx;
    fx5  <= fx4;
    fy5  <= fy4;
    vx5  <= vx4;
    vy5  <= vy4;

    q6.nx     <= (RNW'({pxh5, {KLW{1'b0}}}) + RNW'(pxl5)) << 1;
    q6.ny     <= (RNW'({pyh5, {KLW{1'b0}}}) + RNW'(pyl5)) << 1;
    q6.vel_x  <= vx5;
    q6.vel_y  <= vy5;
    q6.flip_x <= fx5;
    q6.flip_y <= fy5;
  end

  assign t_valid = vld[FRONT_T-1];
  assign t_word  = t4;
  assign q_valid = vld[FRONT_Q-1];
  assign q_word  = q6;

endmodule

/* hdl/psr_tdiv.sv */
// Projection parameter divider, closest point and squared distance test.
// Depends on psr_pkg.
module psr_tdiv (
  input  logic           clk,
  input  logic           rst,
  input  logic           t_valid,
  input  psr_pkg::tdin_t t_word,
  input  psr_pkg::wall_t wall,
  output logic           hit_valid,
  output logic           hit
);
  import psr_pkg::*;

  logic [T_LAT-1:0]     vld;
  tdin_t                dstage [FRAC_BITS];
  logic [FRAC_BITS-1:0] dq     [FRAC_BITS];

  logic [TW-1:0]         tval;
  logic signed [TDW-1:0] tdx1, tdy1;
  logic signed [DW-1:0]  rxa, rya;
  logic signed [DDW-1:0] ddx2, ddy2;
  logic                  inx3, iny3, in4;
  logic [MW-1:0]         magx3, magy3;
  logic [2*MW-1:0]       sqx4, sqy4;
  logic [SQW-1:0]        dsq;
  logic                  fitx, fity;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[T_LAT-2:0], t_valid};
    end
  end

  for (genvar i = 0; i < FRAC_BITS; i++) begin : g_div
    tdin_t                src;
    tdin_t                nxt;
    logic [FRAC_BITS-1:0] srcq;
    logic [DENW:0]        step;
    if (i == 0) begin : g_first
      assign src  = t_word;
      assign srcq = '0;
    end else begin : g_next
      assign src  = dstage[i-1];
      assign srcq = dq[i-1];
    end
    assign step = div_step(src.rem, 1'b0, wall.den);
    always_comb begin
      nxt     = src;
      nxt.rem = step[DENW-1:0];
    end
    always_ff @(posedge clk) begin
      dstage[i] <= nxt;
      dq[i]     <= {srcq[FRAC_BITS-2:0], step[DENW]};
    end
  end

  always_comb begin
    case (dstage[FRAC_BITS-1].tsel)
      TSEL_ZERO: tval = '0;
      TSEL_ONE:  tval = {1'b1, {FRAC_BITS{1'b0}}};
      default:   tval = {1'b0, dq[FRAC_BITS-1]};
    endcase
    fitx = (&ddx2[DDW-1:MW] | ~|ddx2[DDW-1:MW]) && !(ddx2[DDW-1] && ~|ddx2[MW-1:0]);
    fity = (&ddy2[DDW-1:MW] | ~|ddy2[DDW-1:MW]) && !(ddy2[DDW-1] && ~|ddy2[MW-1:0]);
    dsq  = SQW'(sqx4) + SQW'(sqy4);
  end

  always_ff @(posedge clk) begin
    tdx1 <= $signed({1'b0, tval}) * wall.dx;
    tdy1 <= $signed({1'b0, tval}) * wall.dy;
    rxa  <= dstage[FRAC_BITS-1].rx;
    rya  <= dstage[FRAC_BITS-1].ry;

    ddx2 <= DDW'(rxa - (tdx1 >>> FRAC_BITS));
    ddy2 <= DDW'(rya - (tdy1 >>> FRAC_BITS));

    inx3  <= fitx;
    iny3  <= fity;
    magx3 <= ddx2[DDW-1] ? MW'(-ddx2) : ddx2[MW-1:0];
    magy3 <= ddy2[DDW-1] ? MW'(-ddy2) : ddy2[MW-1:0];

    in4  <= inx3 & iny3;
    sqx4 <= magx3 * magx3;
    sqy4 <= magy3 * magy3;

    hit <= in4 && wall.nz && (dsq <= SQW'(wall.thr));
  end

  assign hit_valid = vld[T_LAT-1];

endmodule

/* hdl/psr_qdiv.sv */
// Twin dividers for the mirror correction, then add to velocity and saturate.
// Depends on psr_pkg.
module psr_qdiv (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_valid,
  input  psr_pkg::qdin_t q_word,
  input  psr_pkg::wall_t wall,
  output logic           out_valid,
  output psr_pkg::qdout_t out_word
);
  import psr_pkg::*;

  typedef struct packed {
    logic [DENW-1:0]      remx;
    logic [DENW-1:0]      remy;
    logic [QW-1:0]        nlx;
    logic [QW-1:0]        nly;
    logic [QW-1:0]        qx;
    logic [QW-1:0]        qy;
    logic signed [CW-1:0] vel_x;
    logic signed [CW-1:0] vel_y;
    logic                 flip_x;
    logic                 flip_y;
  } qrow_t;

  logic [Q_LAT-1:0]     vld;
  qrow_t                row [QW];
  qrow_t                head;
  logic signed [EW-1:0] vxe, vye, qxe, qye, cx, cy, sumx, sumy;

  function automatic logic signed [CW-1:0] sat_cw(input logic signed [EW-1:0] v);
    sat_cw = (&v[EW-1:CW-1] | ~|v[EW-1:CW-1]) ? v[CW-1:0] :
             (v[EW-1] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}});
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[Q_LAT-2:0], q_valid};
    end
  end

  always_comb begin
    head.remx   = q_word.nx[RNW-1:QW];
    head.remy   = q_word.ny[RNW-1:QW];
    head.nlx    = q_word.nx[QW-1:0];
    head.nly    = q_word.ny[QW-1:0];
    head.qx     = '0;
    head.qy     = '0;
    head.vel_x  = q_word.vel_x;
    head.vel_y  = q_word.vel_y;
    head.flip_x = q_word.flip_x;
    head.flip_y = q_word.flip_y;
  end

  for (genvar i = 0; i < QW; i++) begin : g_div
    qrow_t         src;
    qrow_t         nxt;
    logic [DENW:0] stx, sty;
    if (i == 0) begin : g_first
      assign src = head;
    end else begin : g_next
      assign src = row[i-1];
    end
    assign stx = div_step(src.remx, src.nlx[QW-1], wall.den);
    assign sty = div_step(src.remy, src.nly[QW-1], wall.den);
    always_comb begin
      nxt      = src;
      nxt.remx = stx[DENW-1:0];
      nxt.remy = sty[DENW-1:0];
      nxt.nlx  = src.nlx << 1;
      nxt.nly  = src.nly << 1;
      nxt.qx   = {src.qx[QW-2:0], stx[DENW]};
      nxt.qy   = {src.qy[QW-2:0], sty[DENW]};
    end
    always_ff @(posedge clk) begin
      row[i] <= nxt;
    end
  end

  always_comb begin
    vxe  = $signed({{(EW-CW){row[QW-1].vel_x[CW-1]}}, row[QW-1].vel_x});
    vye  = $signed({{(EW-CW){row[QW-1].vel_y[CW-1]}}, row[QW-1].vel_y});
    qxe  = $signed({{(EW-QW){1'b0}}, row[QW-1].qx});
    qye  = $signed({{(EW-QW){1'b0}}, row[QW-1].qy});
    cx   = row[QW-1].flip_x ? -qxe : qxe;
    cy   = row[QW-1].flip_y ? -qye : qye;
    sumx = vxe + cx;
    sumy = vye - cy;
  end

  always_ff @(posedge clk) begin
    out_word.nvx   <= sat_cw(sumx);
    out_word.nvy   <= sat_cw(sumy);
    out_word.vel_x <= row[QW-1].vel_x;
    out_word.vel_y <= row[QW-1].vel_y;
  end

  assign out_valid = vld[Q_LAT-1];

endmodule

/* hdl/psr_chk.sv */
// Port-level checks on the reflect block, bound to the top level.
// Depends on psr_pkg and assert_macros.svh.
`include "assert_macros.svh"

module psr_chk (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done,
  input logic cfg_valid,
  input logic cfg_ready
);
  import psr_pkg::*;

  logic [OUT_LAT-1:0] acc_line;

  always_ff @(posedge clk) begin
    if (rst) begin
      acc_line <= '0;
    end else begin
      acc_line <= {acc_line[OUT_LAT-2:0], start & ~busy};
    end
  end

  `PSR_ASSERT_RST(a_rst_quiet, rst |=> busy && !done, "reset must leave busy high and no word out")
  `PSR_ASSERT(a_cfg_busy, cfg_valid && cfg_ready |=> busy, "register write must hold off new words")
  `PSR_ASSERT(a_one_out, done == acc_line[OUT_LAT-1], "result strobe does not match accepted word")

endmodule

bind particle_segment_reflect_top psr_chk u_psr_chk (.*);

/* tb/tb_particle_segment_reflect_top.sv */
// Self-checking bench for particle_segment_reflect_top: drives particle words
// against several wall settings and checks each reflected velocity and hit flag.
// Depends on psr_pkg and the RTL of the block.
module tb_particle_segment_reflect_top;
  import psr_pkg::*;

  localparam int LIMIT = 400000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  in_word_t item = '0;
  logic done;
  out_word_t result;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CIW-1:0] cfg_index = '0;
  logic [CW-1:0] cfg_data = '0;

  particle_segment_reflect_top dut (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // wall as the predictor sees it
  logic signed [31:0] wsx = 0, wsy = 0, wex = 65536, wey = 0;
  logic [30:0] wthr = 31'd33423;

  in_word_t pending_words[$];
  out_word_t expected_words[$];
  int cycle = 0;
  int errors = 0;

  function automatic logic signed [31:0] sat32(input logic signed [127:0] v);
    if (v > 128'sd2147483647) return 32'h7fffffff;
    if (v < -128'sd2147483648) return 32'h80000000;
    return v[31:0];
  endfunction

  function automatic out_word_t reflect_velocity(input in_word_t w);
    logic signed [127:0] sx, sy, px, py, vx, vy, dx, dy, den, num, t, ddx, ddy, k;
    logic signed [127:0] dsq, thr;
    logic [127:0] tq;
    out_word_t r;
    sx = wsx; sy = wsy; px = w.pos_x; py = w.pos_y; vx = w.vel_x; vy = w.vel_y;
    dx = 128'(wex) - sx;
    dy = 128'(wey) - sy;
    dx = $signed(wex) - sx;
    dy = $signed(wey) - sy;
    r.new_vel_x = w.vel_x;
    r.new_vel_y = w.vel_y;
    r.hit = 1'b0;
    if (dx != 0 || dy != 0) begin
      den = dx * dx + dy * dy;
      num = (px - sx) * dx + (py - sy) * dy;
      if (num < 0) t = 0;
      else if (num >= den) t = 128'sd1 << FRAC_BITS;
      else begin
        tq = (num <<< FRAC_BITS) / den;
        t = tq;
      end
      ddx = px - (sx + ((t * dx) >>> FRAC_BITS));
      ddy = py - (sy + ((t * dy) >>> FRAC_BITS));
      if (ddx < 128'sh80000000 && ddx > -128'sh80000000 &&
          ddy < 128'sh80000000 && ddy > -128'sh80000000) begin
        dsq = ddx * ddx + ddy * ddy;
        thr = 128'(wthr) << FRAC_BITS;
        if (dsq <= thr) begin
          k = vy * dx - vx * dy;
          r.new_vel_x = sat32(vx + (2 * k * dy) / den);
          r.new_vel_y = sat32(vy - (2 * k * dx) / den);
          r.hit = 1'b1;
        end
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    errors++;
    $display("MISMATCH %s: got %h expected %h (cycle %0d)", what, got, want, cycle);
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) expected_words.push_back(reflect_velocity(item));
      if (!start || !busy) begin
        if (pending_words.size() > 0 &&
            ((cycle > 1500 && cycle < 2500) || $urandom_range(99) >= 7)) begin
          item <= pending_words.pop_front();
          start <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (!rst && done) begin
      if (expected_words.size() == 0) begin
        errors++;
        $display("UNEXPECTED word at cycle %0d", cycle);
      end else begin
        out_word_t e;
        e = expected_words.pop_front();
        if (result.new_vel_x !== e.new_vel_x)
          report_mismatch("new_vel_x", result.new_vel_x, e.new_vel_x);
        if (result.new_vel_y !== e.new_vel_y)
          report_mismatch("new_vel_y", result.new_vel_y, e.new_vel_y);
        if (result.hit !== e.hit) report_mismatch("hit", 32'(result.hit), 32'(e.hit));
      end
    end
    if (cycle > LIMIT) begin
      $display("Timeout");
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic write_reg(input logic [CIW-1:0] idx, input logic [31:0] d);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    case (idx)
      REG_START_X: wsx = d;
      REG_START_Y: wsy = d;
      REG_END_X: wex = d;
      REG_END_Y: wey = d;
      REG_HIT_DIST_SQ: wthr = d[30:0];
      default: ;
    endcase
    cfg_valid <= 1'b0;
  endtask

  task automatic set_wall(input logic [31:0] a, b, c, d, input logic [31:0] h);
    write_reg(REG_START_X, a);
    write_reg(REG_START_Y, b);
    write_reg(REG_END_X, c);
    write_reg(REG_END_Y, d);
    write_reg(REG_HIT_DIST_SQ, h);
  endtask

  task automatic drain;
    do @(posedge clk);
    while (pending_words.size() != 0 || start || expected_words.size() != 0);
    repeat (45) @(posedge clk);
  endtask

  function automatic logic [31:0] rnd_word;
    case ($urandom_range(5))
      0: return 32'h80000000;
      1: return 32'h7fffffff;
      2: return $urandom_range(2, 0) - 1;
      default: return $urandom;
    endcase
  endfunction

  // particle near the wall so that most words hit
  function automatic in_word_t near_word(input int spread);
    in_word_t w;
    longint t, cx, cy;
    t = $urandom_range(80000) - 8000;
    cx = longint'(wsx) + ((t * (longint'(wex) - longint'(wsx))) >>> 16);
    cy = longint'(wsy) + ((t * (longint'(wey) - longint'(wsy))) >>> 16);
    w.pos_x = 32'(cx + $signed($urandom_range(2 * spread)) - spread);
    w.pos_y = 32'(cy + $signed($urandom_range(2 * spread)) - spread);
    w.vel_x = rnd_word();
    w.vel_y = rnd_word();
    return w;
  endfunction

  task automatic random_words(input int n);
    in_word_t w;
    repeat (n) begin
      case ($urandom_range(9))
        0, 1: begin
          w.pos_x = rnd_word(); w.pos_y = rnd_word();
          w.vel_x = rnd_word(); w.vel_y = rnd_word();
        end
        2: w = near_word(4);
        default: w = near_word(70000);
      endcase
      pending_words.push_back(w);
    end
  endtask

  function automatic in_word_t mk(input logic [31:0] a, b, c, d);
    in_word_t w;
    w.pos_x = a; w.pos_y = b; w.vel_x = c; w.vel_y = d;
    return w;
  endfunction

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    // reset wall: unit segment on the x axis
    pending_words.push_back(mk(32'h8000, 0, 32'h10000, 32'hffff0000));
    pending_words.push_back(mk(32'h8000, 32'h4000, 32'h10000, 0));
    pending_words.push_back(mk(0, 0, 32'h10000, 32'h10000));
    pending_words.push_back(mk(32'h10000, 32'hb000, 32'h7fffffff, 32'h80000000));
    pending_words.push_back(mk(32'hffff8000, 0, 32'h80000000, 32'h7fffffff));
    pending_words.push_back(mk(32'h18000, 32'hffff8000, 5, 7));
    pending_words.push_back(mk(32'h80000000, 32'h80000000, 1, 1));
    pending_words.push_back(mk(32'h7fffffff, 32'h7fffffff, 1, 1));
    pending_words.push_back(mk(32'h80000000, 0, 3, 3));
    pending_words.push_back(mk(32'h4000, 32'h80000000, 3, 3));
    pending_words.push_back(mk(32'h4000, 32'h0000b8a5, 0, 0));
    pending_words.push_back(mk(32'h4000, 32'h0000b8a6, 0, 32'h100));
    pending_words.push_back(mk(32'h4000, 0, 32'h80000000, 32'h80000000));
    pending_words.push_back(mk(32'h4000, 0, 32'h7fffffff, 32'h7fffffff));
    random_words(60);
    drain();
    // zero-length wall passes everything through
    set_wall(32'h12340000, 32'hfff00000, 32'h12340000, 32'hfff00000, 32'h7fffffff);
    pending_words.push_back(mk(32'h12340000, 32'hfff00000, 9, 9));
    random_words(30);
    drain();
    write_reg(3'd6, 32'hffffffff);
    // widest wall
    set_wall(32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
    random_words(150);
    drain();
    set_wall(32'h7fffffff, 32'h80000000, 32'h80000000, 32'h7fffffff, 0);
    random_words(150);
    drain();
    repeat (10) begin
      set_wall($urandom, $urandom, $urandom, $urandom,
               $urandom_range(3) == 0 ? $urandom : $urandom_range(300000));
      random_words(115);
      drain();
    end
    repeat (6) begin
      set_wall($urandom_range(2000000) - 1000000, $urandom_range(2000000) - 1000000,
               $urandom_range(2000000) - 1000000, $urandom_range(2000000) - 1000000,
               $urandom_range(200000));
      random_words(40);
      drain();
    end
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule

/* files.f */
+incdir+hdl
hdl/psr_pkg.sv
hdl/psr_front.sv
hdl/psr_tdiv.sv
hdl/psr_qdiv.sv
hdl/particle_segment_reflect_top.sv
hdl/psr_chk.sv
tb/tb_particle_segment_reflect_top.sv
